>>> rtl/core/s5req_pkg.sv
package s5req_pkg;

  // Protocol field values on the wire
  localparam logic [7:0] SocksVersion  = 8'd5;
  localparam logic [7:0] CmdConnect    = 8'd1;
  localparam logic [7:0] RsvValue      = 8'h00;
  localparam logic [7:0] AtypWireIpv4  = 8'd1;
  localparam logic [7:0] AtypWireName  = 8'd3;
  localparam logic [7:0] AtypWireIpv6  = 8'd4;

  // Byte positions inside the request header
  localparam logic [8:0] PosVer     = 9'd0;
  localparam logic [8:0] PosCmd     = 9'd1;
  localparam logic [8:0] PosRsv     = 9'd2;
  localparam logic [8:0] PosAtyp    = 9'd3;
  localparam logic [8:0] PosNameLen = 9'd4;
  localparam logic [8:0] AddrStart  = 9'd4;
  localparam logic [8:0] NameStart  = 9'd5;
  localparam logic [8:0] Ipv4Len    = 9'd4;
  localparam logic [8:0] Ipv6Len    = 9'd16;
  localparam logic [8:0] PosMax     = 9'd511;

  // Dense reply codes
  typedef enum logic [1:0] {
    REPLY_SUCCESS    = 2'd0,
    REPLY_GEN_FAIL   = 2'd1,
    REPLY_CMD_UNSUP  = 2'd2,
    REPLY_ATYP_UNSUP = 2'd3
  } reply_e;

  // Dense address type codes
  typedef enum logic [1:0] {
    ATYP_IPV4   = 2'd0,
    ATYP_DOMAIN = 2'd1,
    ATYP_IPV6   = 2'd2
  } atyp_e;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    reply_e      reply;
    atyp_e       addr_type;
    logic [15:0] dest_port;
    logic [7:0]  domain_length;
    logic        parse_ok;
    logic        final_item;
  } res_t;

  // Results produced by one byte: zero, one or two
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    logic                room2;
    logic [FifoCntW-1:0] count;
  } fifo_stat_t;

endpackage

>>> rtl/core/s5req_if.sv
interface s5req_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface s5req_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  addr_byte;
  logic [7:0]  addr_index;
  logic [1:0]  reply;
  logic [1:0]  addr_type;
  logic [15:0] dest_port;
  logic [7:0]  domain_length;
  logic        parse_ok;
  logic        final_item;

  modport source (output valid, output kind, output addr_byte, output addr_index,
                  output reply, output addr_type, output dest_port,
                  output domain_length, output parse_ok, output final_item,
                  input ready);
  modport sink   (input valid, input kind, input addr_byte, input addr_index,
                  input reply, input addr_type, input dest_port,
                  input domain_length, input parse_ok, input final_item,
                  output ready);
endinterface

>>> rtl/core/s5req_step.sv
module s5req_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  logic [7:0]     data_byte_i,
  input  logic           eob_i,
  output s5req_pkg::push_t push_o
);
  import s5req_pkg::*;

  logic [8:0] pos_q, pos_d;
  logic       cmd_bad_q, cmd_bad_d;
  atyp_e      type_q, type_d;
  logic [7:0] name_len_q, name_len_d;
  logic [7:0] port_hi_q, port_hi_d;
  logic       done_q, done_d;

  // Values after this byte, before an end flag clears them
  logic       cmd_bad_u;
  atyp_e      type_u;
  logic [7:0] name_len_u;
  logic [7:0] port_hi_u;

  logic       emit_addr, verdict, ok;
  reply_e     reply;
  logic [8:0] start, alen, port_pos;
  res_t       addr_res, verd_res;

  always_comb begin
    start    = (type_q == ATYP_DOMAIN) ? NameStart : AddrStart;
    alen     = (type_q == ATYP_DOMAIN) ? {1'b0, name_len_q} :
               (type_q == ATYP_IPV6) ? Ipv6Len : Ipv4Len;
    port_pos = start + alen;
  end

  always_comb begin
    cmd_bad_u  = cmd_bad_q;
    type_u     = type_q;
    name_len_u = name_len_q;
    port_hi_u  = port_hi_q;
    emit_addr  = 1'b0;
    verdict    = 1'b0;
    ok         = 1'b0;
    reply      = REPLY_GEN_FAIL;
    if (!done_q) begin
      if (pos_q == PosVer) begin
        verdict = (data_byte_i != SocksVersion);
      end else if (pos_q == PosCmd) begin
        cmd_bad_u = (data_byte_i != CmdConnect);
      end else if (pos_q == PosRsv) begin
        verdict = (data_byte_i != RsvValue);
      end else if (pos_q == PosAtyp) begin
        if (cmd_bad_q) begin
          verdict = 1'b1;
          reply   = REPLY_CMD_UNSUP;
        end else if (data_byte_i == AtypWireIpv4) begin
          type_u = ATYP_IPV4;
        end else if (data_byte_i == AtypWireName) begin
          type_u = ATYP_DOMAIN;
        end else if (data_byte_i == AtypWireIpv6) begin
          type_u = ATYP_IPV6;
        end else begin
          verdict = 1'b1;
          reply   = REPLY_ATYP_UNSUP;
        end
      end else if (type_q == ATYP_DOMAIN && pos_q == PosNameLen) begin
        name_len_u = data_byte_i;
      end else if (pos_q >= start && pos_q < port_pos) begin
        emit_addr = 1'b1;
      end else if (pos_q == port_pos) begin
        port_hi_u = data_byte_i;
      end else if (pos_q == port_pos + 9'd1) begin
        verdict = 1'b1;
        reply   = REPLY_SUCCESS;
        ok      = !(type_q == ATYP_DOMAIN && name_len_q == 8'd0);
      end
      if (!verdict && eob_i) begin
        verdict = 1'b1;
        reply   = REPLY_GEN_FAIL;
      end
    end
  end

  always_comb begin
    addr_res               = '0;
    addr_res.kind          = 1'b0;
    addr_res.addr_byte     = data_byte_i;
    addr_res.addr_index    = 8'(pos_q - start);
    verd_res               = '0;
    verd_res.kind          = 1'b1;
    verd_res.final_item    = 1'b1;
    verd_res.reply         = reply;
    verd_res.addr_type     = type_u;
    verd_res.dest_port     = ok ? {port_hi_q, data_byte_i} : 16'd0;
    verd_res.domain_length = name_len_u;
    verd_res.parse_ok      = ok;

    push_o.cnt    = 2'd0;
    push_o.first  = emit_addr ? addr_res : verd_res;
    push_o.second = verd_res;
    if (advance_i) begin
      push_o.cnt = {1'b0, emit_addr} + {1'b0, verdict};
    end
  end

  always_comb begin
    pos_d      = pos_q;
    cmd_bad_d  = cmd_bad_q;
    type_d     = type_q;
    name_len_d = name_len_q;
    port_hi_d  = port_hi_q;
    done_d     = done_q;
    if (advance_i) begin
      if (eob_i) begin
        // End flag rearms for the next request
        pos_d      = '0;
        cmd_bad_d  = 1'b0;
        type_d     = ATYP_IPV4;
        name_len_d = '0;
        port_hi_d  = '0;
        done_d     = 1'b0;
      end else if (!done_q) begin
        cmd_bad_d  = cmd_bad_u;
        type_d     = type_u;
        name_len_d = name_len_u;
        port_hi_d  = port_hi_u;
        if (verdict) begin
          done_d = 1'b1;
        end else if (pos_q != PosMax) begin
          pos_d = pos_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      cmd_bad_q  <= 1'b0;
      type_q     <= ATYP_IPV4;
      name_len_q <= '0;
      port_hi_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      cmd_bad_q  <= cmd_bad_d;
      type_q     <= type_d;
      name_len_q <= name_len_d;
      port_hi_q  <= port_hi_d;
      done_q     <= done_d;
    end
  end

endmodule

>>> rtl/core/s5req_fifo.sv
module s5req_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  s5req_pkg::push_t       push_i,
  input  logic                   pop_i,
  output s5req_pkg::res_t        head_o,
  output logic                   valid_o,
  output s5req_pkg::fifo_stat_t  stat_o
);
  import s5req_pkg::*;

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;
  logic [FifoPtrW-1:0] wr_next;

  assign pop     = pop_i && (cnt_q != '0);
  assign wr_next = wr_q + FifoPtrW'(1);

  always_comb begin
    wr_d  = wr_q + FifoPtrW'(push_i.cnt);
    rd_d  = rd_q + FifoPtrW'(pop);
    cnt_d = cnt_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign valid_o      = (cnt_q != '0);
  assign stat_o.count = cnt_q;
  // Room for the worst case of two results from one byte
  assign stat_o.room2 = (cnt_q <= FifoCntW'(FifoDepth - 2));

endmodule

>>> rtl/core/socks5_connect_request_parser.sv
// SOCKS5 CONNECT request parser. Feed the request one byte per transfer on
// in_i, raising end_of_buffer on the last byte received for this request.
// Each address or domain byte comes back on out_o as a kind 0 transfer, and
// exactly one verdict (kind 1, final_item 1) follows once the port has
// arrived, an error is certain, or the buffer ends. Bytes after a verdict
// give nothing until the end flag, which rearms the parser. The block takes
// one byte per cycle while the result queue has room; each byte passes
// through the input register into the queue. A byte that carries both the
// last address byte and an early end flag yields two results, and out_o
// drains them one per cycle while the sink is ready; the four-entry result
// queue absorbs this, so input stalls only when the sink holds off.
module socks5_connect_request_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  s5req_in_if.sink   in_i,
  s5req_out_if.source out_o
);
  import s5req_pkg::*;

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_eob_q;
  logic       in_xfer;
  logic       advance;

  push_t      push;
  res_t       head;
  logic       head_vld;
  fifo_stat_t fstat;

  assign in_xfer    = in_i.valid && in_i.ready;
  // Advance the held byte only when the queue can take two results
  assign advance    = in_vld_q && fstat.room2;
  assign in_i.ready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload: hold while not refilled
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_i.data_byte;
      in_eob_q  <= in_i.end_of_buffer;
    end
  end

  s5req_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (in_byte_q),
    .eob_i       (in_eob_q),
    .push_o      (push)
  );

  s5req_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_o.ready),
    .head_o (head),
    .valid_o(head_vld),
    .stat_o (fstat)
  );

  // Drive the result channel from the queue head
  assign out_o.valid         = head_vld;
  assign out_o.kind          = head.kind;
  assign out_o.addr_byte     = head.addr_byte;
  assign out_o.addr_index    = head.addr_index;
  assign out_o.reply         = head.reply;
  assign out_o.addr_type     = head.addr_type;
  assign out_o.dest_port     = head.dest_port;
  assign out_o.domain_length = head.domain_length;
  assign out_o.parse_ok      = head.parse_ok;
  assign out_o.final_item    = head.final_item;

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  // One byte never yields more than two results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != 2'd3)
    else $error("too many results for one byte");

  // Results pushed are offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |=> out_o.valid)
    else $error("pushed result not offered");

  // A byte is only advanced with room for two results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (fstat.count <= FifoCntW'(FifoDepth - 2)))
    else $error("advance without queue room");

endmodule

>>> bench/s5req_result_board_pkg.sv
`timescale 1ns / 100ps

package s5req_result_board_pkg;
  import s5req_pkg::*;

  // Predict the parser's results for each accepted byte and check them in order.
  class s5req_result_board;
    res_t        expected_results[$];
    int unsigned mismatches;

    logic [8:0]  pos_count;
    logic        cmd_rejected;
    atyp_e       atyp_latched;
    logic [7:0]  name_len;
    logic [7:0]  port_msb;
    logic        verdict_sent;

    function new();
      mismatches = 0;
      clear_request();
    endfunction

    function void clear_request();
      pos_count    = '0;
      cmd_rejected = 1'b0;
      atyp_latched = ATYP_IPV4;
      name_len     = '0;
      port_msb     = '0;
      verdict_sent = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_byte(logic [7:0] value, logic last);
      res_t       r;
      logic       verdict;
      logic       known;
      logic       ok;
      reply_e     rep;
      logic [15:0] port;
      logic [8:0] start;
      logic [8:0] alen;

      verdict = 1'b0;
      known   = (pos_count >= AddrStart);
      ok      = 1'b0;
      rep     = REPLY_GEN_FAIL;
      port    = '0;

      // Swallow everything after a verdict until the end flag rearms.
      if (verdict_sent) begin
        if (last) clear_request();
        return;
      end

      if (pos_count == PosVer) begin
        if (value != SocksVersion) verdict = 1'b1;
      end else if (pos_count == PosCmd) begin
        cmd_rejected = (value != CmdConnect);
      end else if (pos_count == PosRsv) begin
        if (value != RsvValue) verdict = 1'b1;
      end else if (pos_count == PosAtyp) begin
        if (cmd_rejected) begin
          verdict = 1'b1;
          rep     = REPLY_CMD_UNSUP;
        end else if (value == AtypWireIpv4) begin
          atyp_latched = ATYP_IPV4;
          known        = 1'b1;
        end else if (value == AtypWireName) begin
          atyp_latched = ATYP_DOMAIN;
          known        = 1'b1;
        end else if (value == AtypWireIpv6) begin
          atyp_latched = ATYP_IPV6;
          known        = 1'b1;
        end else begin
          verdict = 1'b1;
          rep     = REPLY_ATYP_UNSUP;
        end
      end else if (atyp_latched == ATYP_DOMAIN && pos_count == PosNameLen) begin
        name_len = value;
      end else begin
        start = (atyp_latched == ATYP_DOMAIN) ? NameStart : AddrStart;
        alen  = (atyp_latched == ATYP_DOMAIN) ? {1'b0, name_len} :
                (atyp_latched == ATYP_IPV6)   ? Ipv6Len : Ipv4Len;
        if (pos_count >= start && pos_count < start + alen) begin
          r            = '0;
          r.addr_byte  = value;
          r.addr_index = 8'(pos_count - start);
          expected_results.push_back(r);
        end else if (pos_count == start + alen) begin
          port_msb = value;
        end else if (pos_count == start + alen + 9'd1) begin
          verdict = 1'b1;
          rep     = REPLY_SUCCESS;
          ok      = !(atyp_latched == ATYP_DOMAIN && name_len == 8'd0);
          if (ok) port = {port_msb, value};
        end
      end

      if (!verdict && last) begin
        verdict = 1'b1;
        rep     = REPLY_GEN_FAIL;
      end

      if (verdict) begin
        r               = '0;
        r.kind          = 1'b1;
        r.reply         = rep;
        r.addr_type     = known ? atyp_latched : ATYP_IPV4;
        r.dest_port     = port;
        r.domain_length = name_len;
        r.parse_ok      = ok;
        r.final_item    = 1'b1;
        expected_results.push_back(r);
        verdict_sent = 1'b1;
      end else if (pos_count != PosMax) begin
        pos_count = pos_count + 9'd1;
      end

      if (last) clear_request();
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: kind %0b", got.kind);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind",          16'(want.kind),          16'(got.kind));
      compare_field("addr_byte",     16'(want.addr_byte),     16'(got.addr_byte));
      compare_field("addr_index",    16'(want.addr_index),    16'(got.addr_index));
      compare_field("reply",         16'(want.reply),         16'(got.reply));
      compare_field("addr_type",     16'(want.addr_type),     16'(got.addr_type));
      compare_field("dest_port",     want.dest_port,          got.dest_port);
      compare_field("domain_length", 16'(want.domain_length), 16'(got.domain_length));
      compare_field("parse_ok",      16'(want.parse_ok),      16'(got.parse_ok));
      compare_field("final_item",    16'(want.final_item),    16'(got.final_item));
    endfunction
  endclass

endpackage

>>> bench/socks5_connect_request_parser_test.sv
`timescale 1ns / 100ps

module socks5_connect_request_parser_test;
  import s5req_pkg::*;
  import s5req_result_board_pkg::*;

  // Traffic per phase, counted in bytes sent; the last request may run past it.
  localparam int unsigned PhaseBytes  = 150;
  // Result queue plus the input register; leave margin for a late extra.
  localparam int unsigned DrainCycles = 12;
  // Far beyond the slowest legal run (~900 bytes, two results each, 50% gaps).
  localparam int unsigned CycleLimit  = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  s5req_in_if  in_if ();
  s5req_out_if out_if ();

  socks5_connect_request_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  s5req_result_board board = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  logic [7:0]  req_bytes[$];

  // Abort a hung run: a lost result would otherwise wait forever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Feed each accepted byte to the predictor. Values read here are the ones
  // present before the edge, since every driver in this bench is nonblocking.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      board.note_byte(in_if.data_byte, in_if.end_of_buffer);
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    res_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind          = out_if.kind;
      got.addr_byte     = out_if.addr_byte;
      got.addr_index    = out_if.addr_index;
      got.reply         = reply_e'(out_if.reply);
      got.addr_type     = atyp_e'(out_if.addr_type);
      got.dest_port     = out_if.dest_port;
      got.domain_length = out_if.domain_length;
      got.parse_ok      = out_if.parse_ok;
      got.final_item    = out_if.final_item;
      board.check_result(got);
    end
  end

  // Receiver back-pressure: one fresh draw per cycle.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one byte, inserting random idle cycles first, and return at the
  // edge where it is taken. Leave valid high so back-to-back bytes need no
  // second assignment in the same step; the caller or the next idle lowers it.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= value;
    in_if.end_of_buffer <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Send req_bytes with the end flag on the last byte.
  task automatic send_request();
    for (int i = 0; i < req_bytes.size(); i++)
      send_byte(req_bytes[i], i == req_bytes.size() - 1);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] other_than(logic [7:0] good);
    logic [7:0] v;
    do v = 8'($urandom); while (v == good);
    return v;
  endfunction

  // Build one random request into req_bytes. Most are well formed with random
  // addresses and ports; the rest carry a bad header byte or are pure noise.
  // The tail is then cut short, left as is, or padded with bytes that follow
  // the verdict and must be ignored.
  function automatic void make_request();
    int unsigned shape;
    int unsigned tail;
    int unsigned alen;
    int unsigned cut;
    int unsigned pick;
    logic [7:0]  atyp_wire;
    logic [7:0]  bad;
    logic [15:0] port;

    req_bytes = {};
    shape = $urandom_range(99);

    if (shape >= 97) begin
      repeat ($urandom_range(8, 1)) req_bytes.push_back(8'($urandom));
      return;
    end

    case ($urandom_range(2))
      0: begin
        atyp_wire = AtypWireIpv4;
        alen      = 4;
      end
      1: begin
        atyp_wire = AtypWireIpv6;
        alen      = 16;
      end
      default: begin
        atyp_wire = AtypWireName;
        // Keep names short; now and then take the longest and the empty one.
        pick = $urandom_range(39);
        if (pick == 0) alen = 255;
        else if (pick <= 4) alen = 0;
        else alen = $urandom_range(24, 1);
      end
    endcase

    req_bytes = {SocksVersion, CmdConnect, RsvValue, atyp_wire};
    if (atyp_wire == AtypWireName) req_bytes.push_back(8'(alen));
    repeat (alen) req_bytes.push_back(8'($urandom));

    case ($urandom_range(7))
      0:       port = 16'h0000;
      1:       port = 16'hFFFF;
      default: port = 16'($urandom);
    endcase
    req_bytes.push_back(port[15:8]);
    req_bytes.push_back(port[7:0]);

    if (shape >= 70 && shape < 78) begin
      req_bytes[0] = other_than(SocksVersion);
    end else if (shape >= 78 && shape < 86) begin
      req_bytes[1] = other_than(CmdConnect);
    end else if (shape >= 86 && shape < 92) begin
      req_bytes[2] = other_than(RsvValue);
      if ($urandom_range(1)) req_bytes[1] = other_than(CmdConnect);
    end else if (shape >= 92) begin
      do bad = 8'($urandom);
      while (bad inside {AtypWireIpv4, AtypWireName, AtypWireIpv6});
      req_bytes[3] = bad;
    end

    tail = $urandom_range(9);
    if (tail == 7) begin
      cut = $urandom_range(req_bytes.size(), 1);
      while (req_bytes.size() > cut) void'(req_bytes.pop_back());
    end else if (tail >= 8) begin
      repeat ($urandom_range(4, 1)) req_bytes.push_back(8'($urandom));
    end
  endfunction

  initial begin : stimulus
    int unsigned phase_count;

    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_buffer = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests, full rate on both sides.

    // Wrong version: verdict at the first byte.
    req_bytes = {8'h00};
    send_request();
    // Wrong version, then a trailing byte that only rearms the parser.
    req_bytes = {8'hFF, SocksVersion};
    send_request();
    // Bad command and bad reserved byte: the reserved-byte failure wins.
    req_bytes = {SocksVersion, 8'hFF, 8'hFF, 8'h00};
    send_request();
    // Bad command with an unknown type: command unsupported at the type byte.
    req_bytes = {SocksVersion, 8'h00, RsvValue, 8'hFF};
    send_request();
    // Unknown address type.
    req_bytes = {SocksVersion, CmdConnect, RsvValue, 8'h02};
    send_request();
    // Buffer ends inside the header.
    req_bytes = {SocksVersion, CmdConnect};
    send_request();
    // Buffer ends on the last IPv4 byte: address byte and verdict together.
    req_bytes = {SocksVersion, CmdConnect, RsvValue, AtypWireIpv4,
                 8'h00, 8'hFF, 8'h80, 8'h7F};
    send_request();
    // Empty domain name: success but not parsed, port forced to zero.
    req_bytes = {SocksVersion, CmdConnect, RsvValue, AtypWireName,
                 8'h00, 8'hFF, 8'hFF};
    send_request();
    // Complete IPv4 request with the highest port.
    req_bytes = {SocksVersion, CmdConnect, RsvValue, AtypWireIpv4,
                 8'hC0, 8'hA8, 8'h01, 8'h01, 8'hFF, 8'hFF};
    send_request();
    wait_drained();

    // Random traffic under four idle/stall mixes; drain between phases so
    // the sender sits out until the result queue is empty.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      phase_count = 0;
      while (phase_count < PhaseBytes) begin
        make_request();
        phase_count += req_bytes.size();
        send_request();
      end
      wait_drained();
    end

    // Allow for any stray result still in flight.
    repeat (DrainCycles) @(posedge clk_i);

    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.mismatches++;
    end

    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
